[rtl/rsbb_pkg.sv]
// Shared types and constants for the balance-ordered record sorter.
package rsbb_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NUM_W       = 31;
    localparam int BAL_W       = 48;
    localparam int POS_W       = 7;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 88;

    typedef struct packed {
        logic [NUM_W-1:0]        num;
        logic signed [BAL_W-1:0] bal;
    } t_rec;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the new record in order
        logic shl;   // move every record one cell toward the head
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

[rtl/record_sort_by_balance_top.sv]
// Top level: stream ports, load/drain control and output register.
//
//  channel  dir  payload (tdata low bit up)                      marks
//  s_*      in   account_number[30:0], balance[78:31], 0[79]      tlast = last_account
//  m_*      out  sorted_number[30:0], sorted_balance[78:31],      tlast = last_out,
//                position[85:79], 0[87:86]                        tuser = dropped
//
// Loading takes one item per cycle; each record is placed in order on arrival.
// After the closing item, the run of n records leaves one per cycle from the head
// cell of the single shift chain. No input is taken while a run drains; output
// stalls freeze the drain. Reset (synchronous, active low) empties the chain and
// the counters at once.
module record_sort_by_balance_top
    import rsbb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // account_number, balance, pad
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // sorted_number, sorted_balance, position, pad
    output logic                o_m_tlast,
    output logic                o_m_tuser    // dropped
);

    t_state            r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_ovf,    n_ovf;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [CNT_W-1:0]  r_pos,    n_pos;
    logic              r_drop,   n_drop;
    logic              r_m_valid, n_m_valid;
    t_rec              r_m_rec;
    logic [POS_W-1:0]  r_m_pos;
    logic              r_m_last;
    logic              r_m_drop;

    t_cell_ctl w_ctl;
    t_rec      w_new;
    t_rec      w_head_rec;
    logic      w_head_valid;
    logic      w_in_acc;
    logic      w_full;
    logic      w_fire;

    assign w_new.num = i_s_tdata[NUM_W-1:0];
    assign w_new.bal = i_s_tdata[NUM_W+BAL_W-1:NUM_W];

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(MAX_RECORDS));
    assign w_fire     = !r_m_valid || i_m_tready;

    rsbb_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_new       (w_new),
        .o_head_rec  (w_head_rec),
        .o_head_valid(w_head_valid)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_remain  = r_remain;
        n_pos     = r_pos;
        n_drop    = r_drop;
        n_m_valid = r_m_valid && !i_m_tready;
        w_ctl     = '0;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_remain = n_count;
                        n_drop   = n_ovf;
                        n_pos    = '0;
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_state  = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_fire) begin
                    w_ctl.shl = 1'b1;
                    n_m_valid = 1'b1;
                    n_pos     = r_pos + 1'b1;
                    n_remain  = r_remain - 1'b1;
                    if (r_remain == CNT_W'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_remain  <= '0;
            r_pos     <= '0;
            r_drop    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_remain  <= n_remain;
            r_pos     <= n_pos;
            r_drop    <= n_drop;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN && w_fire) begin
            r_m_rec  <= w_head_rec;
            r_m_pos  <= POS_W'(n_pos);
            r_m_last <= (r_remain == CNT_W'(1));
            r_m_drop <= r_drop;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_pos, r_m_rec.bal, r_m_rec.num};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_drop;

    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (w_head_valid && r_remain != '0))
        else $error("drain with empty chain");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("overflow flagged with room left");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && w_fire && r_remain == CNT_W'(1)) |=>
        (r_state == ST_LOAD && o_m_tvalid && o_m_tlast))
        else $error("final item does not close the run");

endmodule

[rtl/rsbb_cell.sv]
// One sorter cell: holds a record, compares against the incoming key.
module rsbb_cell
    import rsbb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    input  t_rec      i_left_rec,
    input  logic      i_left_valid,
    input  logic      i_left_take,
    input  t_rec      i_right_rec,
    input  logic      i_right_valid,
    output t_rec      o_rec,
    output logic      o_valid,
    output logic      o_take
);

    t_rec r_rec;
    logic r_valid;
    t_rec n_rec;
    logic n_valid;

    // strict compare keeps equal balances in arrival order
    assign o_take  = !r_valid || (r_rec.bal > i_new.bal);
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctl.ins && o_take) begin
            if (i_left_take) begin
                n_rec   = i_left_rec;
                n_valid = i_left_valid;
            end else begin
                n_rec   = i_new;
                n_valid = 1'b1;
            end
        end else if (i_ctl.shl) begin
            n_rec   = i_right_rec;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[rtl/rsbb_chain.sv]
// Row of sorter cells; the head cell holds the smallest balance.
module rsbb_chain
    import rsbb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    output t_rec      o_head_rec,
    output logic      o_head_valid
);

    t_rec c_rec   [MAX_RECORDS];
    logic c_valid [MAX_RECORDS];
    logic c_take  [MAX_RECORDS];

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        t_rec w_left_rec;
        logic w_left_valid;
        logic w_left_take;
        t_rec w_right_rec;
        logic w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_rec   = i_new;
            assign w_left_valid = 1'b0;
            assign w_left_take  = 1'b0;
        end else begin : g_mid
            assign w_left_rec   = c_rec[g-1];
            assign w_left_valid = c_valid[g-1];
            assign w_left_take  = c_take[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign w_right_rec   = i_new;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_rec   = c_rec[g+1];
            assign w_right_valid = c_valid[g+1];
        end

        rsbb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_new        (i_new),
            .i_left_rec   (w_left_rec),
            .i_left_valid (w_left_valid),
            .i_left_take  (w_left_take),
            .i_right_rec  (w_right_rec),
            .i_right_valid(w_right_valid),
            .o_rec        (c_rec[g]),
            .o_valid      (c_valid[g]),
            .o_take       (c_take[g])
        );
    end

    assign o_head_rec   = c_rec[0];
    assign o_head_valid = c_valid[0];

endmodule

[tb/record_sort_by_balance_top_tb.sv]
// Testbench for the record sorter: random and directed sets checked against a stable sort.
module record_sort_by_balance_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsbb_pkg::*;

    typedef struct {
        logic [NUM_W-1:0]        num;
        logic signed [BAL_W-1:0] bal;
        logic                    last;
    } t_account_item;

    typedef struct {
        logic [NUM_W-1:0]        num;
        logic signed [BAL_W-1:0] bal;
        logic [POS_W-1:0]        pos;
        logic                    last;
        logic                    dropped;
    } t_ranked_record;

    localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};
    localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
    localparam logic [NUM_W-1:0]        NUM_MAX = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;    // account_number, balance, pad
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;         // sorted_number, sorted_balance, position, pad
    logic                o_m_tlast;
    logic                o_m_tuser;         // dropped

    t_account_item  pending_items[$];
    t_rec           open_set[$];
    logic           set_overflow = 1'b0;
    t_ranked_record expected_ranked[$];
    t_account_item  drive_item;
    t_ranked_record want;
    int             send_idle_pct = 30;
    int             recv_idle_pct = 52;
    int             mismatches = 0;

    record_sort_by_balance_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // stable insertion sort of the closed set; only strictly greater balances move right
    function automatic void rank_open_set();
        t_rec           sorted[$];
        t_rec           key;
        int             j;
        t_ranked_record r;
        sorted = open_set;
        for (int i = 1; i < sorted.size(); i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && $signed(sorted[j-1].bal) > $signed(key.bal)) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        for (int i = 0; i < sorted.size(); i++) begin
            r.num     = sorted[i].num;
            r.bal     = sorted[i].bal;
            r.pos     = POS_W'(i + 1);
            r.last    = (i == sorted.size() - 1);
            r.dropped = set_overflow;
            expected_ranked.push_back(r);
        end
        open_set.delete();
        set_overflow = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic logic signed [BAL_W-1:0] pick_balance();
        case ($urandom_range(0, 5))
            0: return BAL_MIN;
            1: return BAL_MAX;
            2: return BAL_W'($signed($urandom_range(0, 3)) - 2);   // ties around zero
            default: return BAL_W'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return NUM_MAX;
            default: return NUM_W'($urandom());
        endcase
    endfunction

    task automatic add_item(logic [NUM_W-1:0] num, logic signed [BAL_W-1:0] bal, logic last);
        t_account_item it;
        it.num  = num;
        it.bal  = bal;
        it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic add_random_set(int size);
        for (int i = 0; i < size; i++)
            add_item(pick_number(), pick_balance(), i == size - 1);
    endtask

    task automatic add_small_sets(int items);
        int size;
        while (items > 0) begin
            size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            add_random_set(size);
            items -= size;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_s_tvalid || expected_ranked.size() != 0)
            @(posedge i_clk);
    endtask

    // sender: next item goes out once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_item = pending_items.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {1'b0, drive_item.bal, drive_item.num};
                i_s_tlast  <= drive_item.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // accepted input items feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (open_set.size() < MAX_RECORDS)
                open_set.push_back(t_rec'{i_s_tdata[NUM_W-1:0],
                                          i_s_tdata[NUM_W+BAL_W-1:NUM_W]});
            else
                set_overflow = 1'b1;
            if (i_s_tlast)
                rank_open_set();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_ranked.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected sorted item, expected none actual %h", $time,
                         o_m_tdata);
            end else begin
                want = expected_ranked.pop_front();
                check_field("sorted_number", 64'(want.num), 64'(o_m_tdata[NUM_W-1:0]));
                check_field("sorted_balance", 64'($unsigned(want.bal)),
                            64'(o_m_tdata[NUM_W+BAL_W-1:NUM_W]));
                check_field("position", 64'(want.pos),
                            64'(o_m_tdata[NUM_W+BAL_W+POS_W-1:NUM_W+BAL_W]));
                check_field("last_out", 64'(want.last), 64'(o_m_tlast));
                check_field("dropped", 64'(want.dropped), 64'(o_m_tuser));
            end
        end
    end

    initial begin
        wait (i_rst_n);
        // single-record sets at the extremes
        add_item(NUM_MAX, BAL_MAX, 1'b1);
        add_item('0, BAL_MIN, 1'b1);
        // extremes mixed with ties; equal balances must keep arrival order
        add_item(31'h5555_5555, '0, 1'b0);
        add_item(31'h2AAA_AAAA, -48'sd1, 1'b0);
        add_item(31'd1, BAL_MIN, 1'b0);
        add_item(31'd2, BAL_MAX, 1'b0);
        add_item(31'd3, 48'sd5, 1'b0);
        add_item(31'd4, -48'sd1, 1'b0);
        add_item(31'd5, '0, 1'b0);
        add_item(31'd6, BAL_MIN, 1'b1);
        // reverse order
        for (int i = 0; i < 5; i++)
            add_item(NUM_W'(100 + i), BAL_W'(4 - i), i == 4);
        add_small_sets(18);
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 30;
        // two records past capacity, closing item among the dropped
        add_random_set(MAX_RECORDS + 2);
        add_small_sets(8);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // store exactly full, nothing dropped
        add_random_set(MAX_RECORDS);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_ranked.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[record_sort_by_balance_top.f]
rtl/rsbb_pkg.sv
rtl/rsbb_cell.sv
rtl/rsbb_chain.sv
rtl/record_sort_by_balance_top.sv
tb/record_sort_by_balance_top_tb.sv
